>>> hdl/cce_pkg.sv
// ----------------------------------------------------------------------------
// cce_pkg
// Shared types and constants for the cubic curve evaluator: number formats,
// register indexes, derivative order codes, coefficient sequencer types.
// ----------------------------------------------------------------------------
package cce_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int SPAN_W      = 31;
  localparam int ORDER_W     = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // cubic coefficient, 2*FRAC_BITS fractional bits
  localparam int COEF_W      = 48;

  // horner datapath
  localparam int HORNER_W    = 95;
  localparam int HSTEPS      = 3;
  localparam int CHUNK_W     = 32;
  localparam int MUL_A_W     = 3 * CHUNK_W;
  localparam int PP_W        = CHUNK_W + 1 + VALUE_WIDTH;
  localparam int SUM_W       = MUL_A_W + VALUE_WIDTH;
  localparam int STAGES      = 2 * HSTEPS + 2;
  localparam int OUT_STG     = STAGES - 1;

  // coefficient unit
  localparam int SQ_W        = 2 * SPAN_W;
  localparam int NUM_W       = 96;
  localparam int DEN_W       = 3 * SPAN_W;
  localparam int DIV_STEPS   = NUM_W + 2 * FRAC_BITS - 1;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int MUL_OP_W    = SPAN_W + 2;
  localparam int MUL_P_W     = 2 * MUL_OP_W;
  localparam int PROD_W      = 64;

  localparam logic [CFG_IDX_W-1:0] REG_START_VALUE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_SLOPE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_CURVATURE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_VALUE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_LENGTH     = 3'd4;

  localparam logic [ORDER_W-1:0] ORDER_VALUE     = 3'd0;
  localparam logic [ORDER_W-1:0] ORDER_SLOPE     = 3'd1;
  localparam logic [ORDER_W-1:0] ORDER_CURVATURE = 3'd2;
  localparam logic [ORDER_W-1:0] ORDER_JERK      = 3'd3;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] start_value;
    logic signed [VALUE_WIDTH-1:0] start_slope;
    logic signed [VALUE_WIDTH-1:0] start_curvature;
    logic signed [VALUE_WIDTH-1:0] end_value;
    logic        [SPAN_W-1:0]      span_length;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    start_value:     '0,
    start_slope:     '0,
    start_curvature: '0,
    end_value:       '0,
    span_length:     SPAN_W'(1 << FRAC_BITS)
  };

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_MUL,
    CS_ACC,
    CS_DIV,
    CS_FIX
  } coef_state_t;

  typedef enum logic [2:0] {
    OP_SPAN_SQ,
    OP_SLOPE_SPAN,
    OP_CURV_LO,
    OP_CURV_HI,
    OP_CUBE_LO,
    OP_CUBE_HI
  } coef_op_t;

endpackage

>>> hdl/cce_intf.sv
// ----------------------------------------------------------------------------
// cce_intf
// Valid/ready channels of the cubic curve evaluator: evaluation requests in,
// curve results out.
// ----------------------------------------------------------------------------
interface cce_in_if;
  import cce_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] eval_point;
  logic        [ORDER_W-1:0]     deriv_order;

  modport source (output valid, eval_point, deriv_order, input ready);
  modport sink   (input valid, eval_point, deriv_order, output ready);
endinterface

interface cce_out_if;
  import cce_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] curve_result;
  logic                          saturated;

  modport source (output valid, curve_result, saturated, input ready);
  modport sink   (input valid, curve_result, saturated, output ready);
endinterface

>>> hdl/cce_coef_unit.sv
// ----------------------------------------------------------------------------
// cce_coef_unit
// Works out the cubic coefficient c3 from the curve registers: a shared
// multiplier builds numerator and span cube, then a restoring divider
// produces one quotient bit per cycle and the result is saturated.
// ----------------------------------------------------------------------------
module cce_coef_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  cce_pkg::cfg_regs_t                 cfg,
  output logic signed [cce_pkg::COEF_W-1:0]  coef,
  output logic                               coef_ready
);
  import cce_pkg::*;

  coef_state_t state_r, state_nxt;
  coef_op_t    op_r, op_nxt;

  logic signed [MUL_OP_W-1:0]   mul_a;
  logic signed [MUL_OP_W-1:0]   mul_b;
  logic signed [MUL_P_W-1:0]    mul_p;
  logic signed [PROD_W-1:0]     prod_r;
  logic        [SQ_W-1:0]       t2_r;
  logic signed [NUM_W-1:0]      num_r;
  logic signed [NUM_W-1:0]      diff;
  logic        [DEN_W-1:0]      den_r;
  logic        [NUM_W-1:0]      mag_r;
  logic                         neg_r;
  logic        [DEN_W-1:0]      rem_r;
  logic        [DEN_W:0]        trial;
  logic        [DEN_W:0]        trial_sub;
  logic                         trial_ge;
  logic        [COEF_W-1:0]     quo_r;
  logic                         ovf_r;
  logic        [DIV_CNT_W-1:0]  cnt_r;
  logic signed [COEF_W-1:0]     coef_r;
  logic                         ready_r;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST  = DIV_CNT_W'(DIV_STEPS - 1);
  localparam logic [COEF_W-1:0]    NEG_LIMIT = COEF_W'(1) << (COEF_W - 1);
  localparam logic signed [COEF_W-1:0] COEF_MAX = $signed(NEG_LIMIT - COEF_W'(1));
  localparam logic signed [COEF_W-1:0] COEF_MIN = $signed(NEG_LIMIT);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = MUL_OP_W'(cfg.span_length);
    unique case (op_r)
      OP_SPAN_SQ:    mul_a = MUL_OP_W'(cfg.span_length);
      OP_SLOPE_SPAN: mul_a = MUL_OP_W'(cfg.start_slope);
      OP_CURV_LO: begin
        mul_a = MUL_OP_W'(cfg.start_curvature);
        mul_b = MUL_OP_W'(t2_r[SPAN_W-1:0]);
      end
      OP_CURV_HI: begin
        mul_a = MUL_OP_W'(cfg.start_curvature);
        mul_b = MUL_OP_W'(t2_r[SQ_W-1:SPAN_W]);
      end
      OP_CUBE_LO:    mul_a = MUL_OP_W'(t2_r[SPAN_W-1:0]);
      OP_CUBE_HI:    mul_a = MUL_OP_W'(t2_r[SQ_W-1:SPAN_W]);
      default:       mul_a = '0;
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign diff  = NUM_W'(cfg.end_value) - NUM_W'(cfg.start_value);

  // restoring divide step
  assign trial     = {rem_r, mag_r[NUM_W-1]};
  assign trial_ge  = trial >= {1'b0, den_r};
  assign trial_sub = trial - {1'b0, den_r};

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    if (start) begin
      state_nxt = CS_MUL;
      op_nxt    = OP_SPAN_SQ;
    end else begin
      unique case (state_r)
        CS_IDLE: state_nxt = CS_IDLE;
        CS_MUL:  state_nxt = CS_ACC;
        CS_ACC: begin
          if (op_r == OP_CUBE_HI) begin
            state_nxt = CS_DIV;
          end else begin
            state_nxt = CS_MUL;
            op_nxt    = coef_op_t'(3'(op_r + 3'd1));
          end
        end
        CS_DIV:  if (cnt_r == DIV_LAST) state_nxt = CS_FIX;
        CS_FIX:  state_nxt = CS_IDLE;
        default: state_nxt = CS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
      op_r    <= OP_SPAN_SQ;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b1;
      coef_r  <= '0;
    end else if (start) begin
      ready_r <= 1'b0;
    end else if (state_r == CS_FIX) begin
      ready_r <= 1'b1;
      if (cfg.span_length == '0) begin
        coef_r <= '0;
      end else if (!neg_r) begin
        coef_r <= (ovf_r || quo_r[COEF_W-1]) ? COEF_MAX : $signed(quo_r);
      end else begin
        coef_r <= (ovf_r || quo_r > NEG_LIMIT) ? COEF_MIN : -$signed(quo_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      CS_MUL: prod_r <= $signed(mul_p[PROD_W-1:0]);
      CS_ACC: begin
        unique case (op_r)
          OP_SPAN_SQ:    t2_r <= prod_r[SQ_W-1:0];
          OP_SLOPE_SPAN: num_r <= (diff <<< (2 * FRAC_BITS + 1))
                                  - (NUM_W'(prod_r) <<< (FRAC_BITS + 1));
          OP_CURV_LO:    num_r <= num_r - NUM_W'(prod_r);
          OP_CURV_HI:    num_r <= num_r - (NUM_W'(prod_r) <<< SPAN_W);
          OP_CUBE_LO:    den_r <= DEN_W'(prod_r[SQ_W-1:0]);
          OP_CUBE_HI: begin
            den_r <= den_r + (DEN_W'(prod_r[SQ_W-1:0]) << SPAN_W);
            neg_r <= num_r[NUM_W-1];
            mag_r <= num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
            rem_r <= '0;
            quo_r <= '0;
            ovf_r <= 1'b0;
            cnt_r <= '0;
          end
          default: t2_r <= t2_r;
        endcase
      end
      CS_DIV: begin
        rem_r <= trial_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        mag_r <= mag_r << 1;
        quo_r <= {quo_r[COEF_W-2:0], trial_ge};
        ovf_r <= ovf_r | quo_r[COEF_W-1];
        cnt_r <= cnt_r + DIV_CNT_W'(1);
      end
      default: cnt_r <= cnt_r;
    endcase
  end

  assign coef       = coef_r;
  assign coef_ready = ready_r;

endmodule

>>> hdl/cubic_curve_evaluator_core.sv
// ----------------------------------------------------------------------------
// cubic_curve_evaluator_core
// Evaluates a cubic curve or one of its derivatives at a requested point.
//
// cfg port: write cfg_wdata to register cfg_index while cfg_we is high;
//   0 start value, 1 start slope, 2 start curvature, 3 end value, 4 span.
//   Higher indexes are ignored. Write only while no request is in flight.
// After any register write the cubic coefficient is recomputed (shared
//   multiplier steps, divide steps and a saturation step); in_chan.ready
//   stays low for that time.
// in_chan: point (signed Q16.16) and derivative order 0..3, higher gives 0.
// out_chan: result (signed Q16.16) and a saturation flag.
// Throughput is one request per cycle while out_chan and the coefficient
//   unit do not stall it; from request to result lie an entry stage, three
//   horner steps of multiply and sum stages, and a saturating output register.
// Each stage moves on when it is empty or the next one moves, so a stall of
//   out_chan fills the bubbles before it backs up into in_chan.ready.
// Reset returns the registers to their defaults (span 1.0) and empties
//   the pipeline; the coefficient is ready right after reset.
// ----------------------------------------------------------------------------
module cubic_curve_evaluator_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [cce_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cce_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  cce_in_if.sink                             in_chan,
  cce_out_if.source                          out_chan
);
  import cce_pkg::*;

  cfg_regs_t                     cfg_r;
  logic                          cfg_hit;
  logic signed [COEF_W-1:0]      coef;
  logic                          coef_ready;

  logic [STAGES-1:0]             vld_r;
  logic [STAGES-1:0]             adv;
  logic                          in_fire;

  logic signed [HORNER_W-1:0]    val_r  [STAGES-1];
  logic signed [VALUE_WIDTH-1:0] p_r    [STAGES-1];
  logic        [HSTEPS-1:0]      en_r   [STAGES-1];
  logic                          ord0_r [STAGES-1];

  logic signed [PP_W-1:0]        pp0_r  [HSTEPS];
  logic signed [PP_W-1:0]        pp1_r  [HSTEPS];
  logic signed [PP_W-1:0]        pp2_r  [HSTEPS];

  logic signed [COEF_W+1:0]      coef_x3;
  logic signed [HORNER_W-1:0]    lead;
  logic [HORNER_W-FRAC_BITS-VALUE_WIDTH:0] top_bits;
  logic                          fits;

  logic signed [VALUE_WIDTH-1:0] res_r;
  logic                          sat_r;

  localparam logic signed [VALUE_WIDTH-1:0] RES_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] RES_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  // configuration registers
  assign cfg_hit = cfg_we && (cfg_index <= REG_SPAN_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_VALUE:     cfg_r.start_value     <= $signed(cfg_wdata);
        REG_START_SLOPE:     cfg_r.start_slope     <= $signed(cfg_wdata);
        REG_START_CURVATURE: cfg_r.start_curvature <= $signed(cfg_wdata);
        REG_END_VALUE:       cfg_r.end_value       <= $signed(cfg_wdata);
        REG_SPAN_LENGTH:     cfg_r.span_length     <= cfg_wdata[SPAN_W-1:0];
        default:             cfg_r <= cfg_r;
      endcase
    end
  end

  cce_coef_unit u_coef (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (cfg_hit),
    .cfg        (cfg_r),
    .coef       (coef),
    .coef_ready (coef_ready)
  );

  // stage advance chain
  always_comb begin
    adv[OUT_STG] = !vld_r[OUT_STG] || out_chan.ready;
    for (int k = OUT_STG - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_chan.ready = adv[0] && coef_ready;
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_fire;
      for (int k = 1; k < STAGES; k++) begin
        if (adv[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // entry stage: leading coefficient for the requested order
  assign coef_x3 = (COEF_W+2)'(coef) + ((COEF_W+2)'(coef) <<< 1);

  always_comb begin
    unique case (in_chan.deriv_order)
      ORDER_VALUE:     lead = HORNER_W'(coef);
      ORDER_SLOPE:     lead = HORNER_W'(coef_x3);
      ORDER_CURVATURE: lead = HORNER_W'(coef_x3) <<< 1;
      ORDER_JERK:      lead = HORNER_W'(coef_x3) <<< 1;
      default:         lead = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      val_r[0]  <= lead;
      p_r[0]    <= in_chan.eval_point;
      ord0_r[0] <= (in_chan.deriv_order == ORDER_VALUE);
      en_r[0]   <= {in_chan.deriv_order == ORDER_VALUE,
                    in_chan.deriv_order <= ORDER_SLOPE,
                    in_chan.deriv_order <= ORDER_CURVATURE};
    end
  end

  // horner steps: partial products, then sum, scale and add the term (or pass the value on when the step is off)
  for (genvar k = 0; k < HSTEPS; k++) begin : g_step
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [SUM_W-1:0]    sum;
    logic signed [HORNER_W-1:0] scaled;
    logic signed [HORNER_W-1:0] term;

    assign mul_a = MUL_A_W'(val_r[2*k]);

    always_ff @(posedge clk) begin
      if (adv[2*k+1]) begin
        pp0_r[k]      <= $signed({1'b0, mul_a[CHUNK_W-1:0]}) * p_r[2*k];
        pp1_r[k]      <= $signed({1'b0, mul_a[2*CHUNK_W-1:CHUNK_W]}) * p_r[2*k];
        pp2_r[k]      <= $signed(mul_a[MUL_A_W-1:2*CHUNK_W]) * p_r[2*k];
        val_r[2*k+1]  <= val_r[2*k];
        p_r[2*k+1]    <= p_r[2*k];
        en_r[2*k+1]   <= en_r[2*k];
        ord0_r[2*k+1] <= ord0_r[2*k];
      end
    end

    assign sum = SUM_W'(pp0_r[k])
               + (SUM_W'(pp1_r[k]) <<< CHUNK_W)
               + (SUM_W'(pp2_r[k]) <<< (2 * CHUNK_W));
    assign scaled = $signed(sum[HORNER_W+FRAC_BITS-1:FRAC_BITS]);

    if (k == 0) begin : g_term_curv
      assign term = ord0_r[2*k+1]
                  ? HORNER_W'(cfg_r.start_curvature) <<< (FRAC_BITS - 1)
                  : HORNER_W'(cfg_r.start_curvature) <<< FRAC_BITS;
    end else if (k == 1) begin : g_term_slope
      assign term = HORNER_W'(cfg_r.start_slope) <<< FRAC_BITS;
    end else begin : g_term_value
      assign term = HORNER_W'(cfg_r.start_value) <<< FRAC_BITS;
    end

    always_ff @(posedge clk) begin
      if (adv[2*k+2]) begin
        val_r[2*k+2]  <= en_r[2*k+1][k] ? scaled + term : val_r[2*k+1];
        p_r[2*k+2]    <= p_r[2*k+1];
        en_r[2*k+2]   <= en_r[2*k+1];
        ord0_r[2*k+2] <= ord0_r[2*k+1];
      end
    end
  end

  // output stage: drop the extra fraction bits and saturate
  assign top_bits = val_r[OUT_STG-1][HORNER_W-1:FRAC_BITS+VALUE_WIDTH-1];
  assign fits     = (&top_bits) || !(|top_bits);

  always_ff @(posedge clk) begin
    if (adv[OUT_STG]) begin
      sat_r <= !fits;
      if (fits) begin
        res_r <= $signed(val_r[OUT_STG-1][FRAC_BITS+VALUE_WIDTH-1:FRAC_BITS]);
      end else begin
        res_r <= val_r[OUT_STG-1][HORNER_W-1] ? RES_MIN : RES_MAX;
      end
    end
  end

  assign out_chan.valid        = vld_r[OUT_STG];
  assign out_chan.curve_result = res_r;
  assign out_chan.saturated    = sat_r;

endmodule
